/* hw/rtl/twc_pkg.sv */
// Shared constants, codes and types of the text console writer.
`timescale 1ns / 1ps
package twc_pkg;

   // Screen geometry
   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam int LAST_CELL  = CELL_COUNT - 1;
   localparam int COPY_LAST  = (ROWS - 1) * COLUMNS;  // cells moved by one scroll
   localparam int ADDR_W     = $clog2(CELL_COUNT);

   // Field widths
   localparam int OP_W    = 2;
   localparam int CHAR_W  = 8;
   localparam int INDEX_W = 11;
   localparam int CELL_W  = 16;
   localparam int COL_W   = 7;
   localparam int ROW_W   = 5;
   localparam int COLOR_W = 8;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Operation codes
   localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;

   localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'h0A;
   localparam logic [CHAR_W-1:0]  SPACE_CODE   = 8'h20;
   localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'h0F;
   localparam logic [CELL_W-1:0]  RESET_BLANK  = {RESET_COLOR, SPACE_CODE};

   typedef enum logic [2:0] {
      CMD_PUT,
      CMD_NEWLINE,
      CMD_CLEAR,
      CMD_READ,
      CMD_NOP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type             kind;
      logic [CHAR_W-1:0]        char_code;
      logic [ADDR_W-1:0]        cell_addr;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ_WAIT,
      ST_SCROLL_COPY,
      ST_SCROLL_BLANK,
      ST_CLEAR
   } back_state_type;

endpackage

/* hw/rtl/twc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module twc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/twc_front.sv */
// Front end: accepts request beats and decodes them into screen commands.
`timescale 1ns / 1ps
module twc_front (
   input  logic                   req_valid,
   input  logic [twc_pkg::OP_W-1:0]    req_operation,
   input  logic [twc_pkg::CHAR_W-1:0]  req_char_code,
   input  logic [twc_pkg::INDEX_W-1:0] req_cell_index,
   input  logic                   q_full,
   input  logic                   init_busy,
   output logic                   req_stall,
   output logic                   push_valid,
   output twc_pkg::cmd_type       push_cmd
);
   import twc_pkg::*;

   logic in_range;

   assign req_stall  = q_full || init_busy;
   assign push_valid = req_valid && !req_stall;
   assign in_range   = 32'(req_cell_index) < 32'(CELL_COUNT);

   always_comb begin
      push_cmd.char_code = req_char_code;
      push_cmd.cell_addr = ADDR_W'(req_cell_index);
      case (req_operation)
         OP_WRITE: begin
            push_cmd.kind = (req_char_code == NEWLINE_CODE) ? CMD_NEWLINE : CMD_PUT;
         end
         OP_CLEAR: begin
            push_cmd.kind = CMD_CLEAR;
         end
         OP_READ: begin
            // out-of-range reads just report the cursor
            push_cmd.kind = in_range ? CMD_READ : CMD_NOP;
         end
         default: begin
            push_cmd.kind = CMD_NOP;
         end
      endcase
   end

endmodule

/* hw/rtl/twc_queue.sv */
// Short command FIFO decoupling the front end from the screen engine.
`timescale 1ns / 1ps
module twc_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  twc_pkg::cmd_type push_cmd,
   input  logic             pop,
   output twc_pkg::cmd_type pop_cmd,
   output logic             q_full,
   output logic             q_empty
);
   import twc_pkg::*;

   cmd_type           entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign q_full  = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign q_empty = count_ff == '0;
   assign do_push = push_valid && !q_full;
   assign do_pop  = pop && !q_empty;
   assign pop_cmd = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* hw/rtl/twc_back.sv */
// Screen engine: executes commands on the cell RAM and drives the result register.
`timescale 1ns / 1ps
module twc_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [twc_pkg::COLOR_W-1:0] text_color,
   input  logic                        q_empty,
   input  twc_pkg::cmd_type            pop_cmd,
   output logic                        pop,
   output logic                        init_busy,
   input  logic                        rsp_stall,
   output logic                        rsp_valid,
   output logic [twc_pkg::CELL_W-1:0]  rsp_cell_value,
   output logic [twc_pkg::COL_W-1:0]   rsp_cursor_col,
   output logic [twc_pkg::ROW_W-1:0]   rsp_cursor_row
);
   import twc_pkg::*;

   back_state_type    state_ff, state_in;
   logic [COL_W-1:0]  cur_col_ff, cur_col_in;
   logic [ROW_W-1:0]  cur_row_ff, cur_row_in;
   logic [ADDR_W-1:0] sweep_ff, sweep_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CELL_W-1:0] rsp_cell_ff;
   logic [COL_W-1:0]  rsp_col_ff;
   logic [ROW_W-1:0]  rsp_row_ff;

   logic              out_free;
   logic              emit;
   logic [CELL_W-1:0] emit_cell;
   logic [COL_W:0]    col_inc;
   logic [ROW_W:0]    row_inc;
   logic              row_step;
   logic              wrap;
   logic [COL_W-1:0]  adv_col;
   logic [ROW_W-1:0]  adv_row;
   logic [ADDR_W-1:0] cursor_addr;
   logic [CELL_W-1:0] color_blank;
   logic              sweep_last;
   logic              copy_last;

   logic              ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0] ram_wr_addr, ram_rd_addr;
   logic [CELL_W-1:0] ram_wr_data, ram_rd_data;

   twc_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELL_COUNT)
   ) u_screen (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign pop         = (state_ff == ST_IDLE) && !q_empty && out_free;
   assign init_busy   = state_ff == ST_INIT;
   assign color_blank = {text_color, SPACE_CODE};
   assign sweep_last  = sweep_ff == ADDR_W'(LAST_CELL);
   assign copy_last   = sweep_ff == ADDR_W'(COPY_LAST);
   assign cursor_addr = ADDR_W'(cur_row_ff) * ADDR_W'(COLUMNS) + ADDR_W'(cur_col_ff);

   // cursor advance for a character or a newline
   always_comb begin
      col_inc  = {1'b0, cur_col_ff} + 1'b1;
      row_inc  = {1'b0, cur_row_ff} + 1'b1;
      if (pop_cmd.kind == CMD_NEWLINE || 32'(col_inc) >= 32'(COLUMNS)) begin
         adv_col  = '0;
         row_step = 1'b1;
      end else begin
         adv_col  = col_inc[COL_W-1:0];
         row_step = 1'b0;
      end
      wrap = row_step && (32'(row_inc) >= 32'(ROWS));
      if (!row_step) begin
         adv_row = cur_row_ff;
      end else if (wrap) begin
         adv_row = ROW_W'(ROWS - 1);
      end else begin
         adv_row = row_inc[ROW_W-1:0];
      end
   end

   // next state and sequencing registers
   always_comb begin
      state_in   = state_ff;
      cur_col_in = cur_col_ff;
      cur_row_in = cur_row_ff;
      sweep_in   = sweep_ff;
      case (state_ff)
         ST_INIT: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            sweep_in = '0;
            if (pop) begin
               case (pop_cmd.kind)
                  CMD_PUT, CMD_NEWLINE: begin
                     cur_col_in = adv_col;
                     cur_row_in = adv_row;
                     if (wrap) begin
                        state_in = ST_SCROLL_COPY;
                     end
                  end
                  CMD_CLEAR: begin
                     cur_col_in = '0;
                     cur_row_in = '0;
                     state_in   = ST_CLEAR;
                  end
                  CMD_READ: begin
                     state_in = ST_READ_WAIT;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_READ_WAIT: begin
            state_in = ST_IDLE;
         end
         ST_SCROLL_COPY: begin
            if (copy_last) begin
               state_in = ST_SCROLL_BLANK;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         ST_SCROLL_BLANK, ST_CLEAR: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // RAM controls and result emission
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = sweep_ff;
      ram_wr_data = color_blank;
      ram_rd_en   = 1'b0;
      ram_rd_addr = pop_cmd.cell_addr;
      emit        = 1'b0;
      emit_cell   = '0;
      case (state_ff)
         ST_INIT: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = RESET_BLANK;
         end
         ST_IDLE: begin
            if (pop) begin
               case (pop_cmd.kind)
                  CMD_PUT: begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = cursor_addr;
                     ram_wr_data = {text_color, pop_cmd.char_code};
                     emit        = !wrap;
                  end
                  CMD_NEWLINE: begin
                     emit = !wrap;
                  end
                  CMD_READ: begin
                     ram_rd_en = 1'b1;
                  end
                  CMD_NOP: begin
                     emit = 1'b1;
                  end
                  default: begin
                     emit = 1'b0;
                  end
               endcase
            end
         end
         ST_READ_WAIT: begin
            emit      = 1'b1;
            emit_cell = ram_rd_data;
         end
         ST_SCROLL_COPY: begin
            // read one row ahead, write the previous beat's data one cell back
            ram_wr_en   = sweep_ff != '0;
            ram_wr_addr = sweep_ff - 1'b1;
            ram_wr_data = ram_rd_data;
            ram_rd_en   = !copy_last;
            ram_rd_addr = sweep_ff + ADDR_W'(COLUMNS);
         end
         ST_SCROLL_BLANK, ST_CLEAR: begin
            ram_wr_en = 1'b1;
            emit      = sweep_last;
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_cell_ff <= emit_cell;
         rsp_col_ff  <= cur_col_in;
         rsp_row_ff  <= cur_row_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_value = rsp_cell_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cursor_row = rsp_row_ff;

endmodule

/* hw/rtl/text_console_writer.sv */
// Top level of the text console writer: front end, command queue, screen engine.
`timescale 1ns / 1ps
// Keeps an 80x25 text screen of 16-bit cells (attribute byte above character
// byte) in a single-port-write / single-port-read RAM, plus a cursor. Each
// request beat gives exactly one response beat carrying the cursor after the
// item and, for a read, the cell. After reset the engine sweeps the RAM to
// blanks (0x0F20), one cell a cycle, with req_stall held high; the colour
// register can be written meanwhile. A character, newline, out-of-range
// read or unused operation is handled in the idle state; an in-range read
// also passes through the read-wait state (registered RAM read). A clear
// writes every cell, one cell write a cycle. A character or newline that
// runs off the bottom row triggers a scroll copying rows up (one cell read
// and one cell write per cycle, limited by the single write port), then
// blanks the bottom row. A two-beat command queue lets the front end accept
// beats until full while the engine works and a response waits on rsp_stall.
// Colour changes apply only to cells written or blanked afterwards.
module text_console_writer (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [twc_pkg::OP_W-1:0]    req_operation,
   input  logic [twc_pkg::CHAR_W-1:0]  req_char_code,
   input  logic [twc_pkg::INDEX_W-1:0] req_cell_index,
   input  logic                        req_end_of_string,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [twc_pkg::CELL_W-1:0]  rsp_cell_value,
   output logic [twc_pkg::COL_W-1:0]   rsp_cursor_col,
   output logic [twc_pkg::ROW_W-1:0]   rsp_cursor_row,
   // colour register write
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [twc_pkg::COLOR_W-1:0] csr_text_color
);
   import twc_pkg::*;

   logic [COLOR_W-1:0] text_color_ff, text_color_in;
   logic               q_full, q_empty;
   logic               push_valid;
   cmd_type            push_cmd, pop_cmd;
   logic               pop;
   logic               init_busy;

   // colour register; always ready. end_of_string only marks string ends
   // for the software side and takes no part in screen behaviour.
   assign csr_ready     = 1'b1;
   assign text_color_in = (csr_valid && csr_ready) ? csr_text_color : text_color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         text_color_ff <= RESET_COLOR;
      end else begin
         text_color_ff <= text_color_in;
      end
   end

   twc_front u_front (
      .req_valid      (req_valid),
      .req_operation  (req_operation),
      .req_char_code  (req_char_code),
      .req_cell_index (req_cell_index),
      .q_full         (q_full),
      .init_busy      (init_busy),
      .req_stall      (req_stall),
      .push_valid     (push_valid),
      .push_cmd       (push_cmd)
   );

   twc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .pop_cmd    (pop_cmd),
      .q_full     (q_full),
      .q_empty    (q_empty)
   );

   twc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .text_color     (text_color_ff),
      .q_empty        (q_empty),
      .pop_cmd        (pop_cmd),
      .pop            (pop),
      .init_busy      (init_busy),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_cell_value (rsp_cell_value),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_cursor_row (rsp_cursor_row)
   );

endmodule

/* hw/rtl/twc_checker.sv */
// Port-level checks of the text console writer, bound to the top level.
`timescale 1ns / 1ps
module twc_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [twc_pkg::CELL_W-1:0]  rsp_cell_value,
   input logic [twc_pkg::COL_W-1:0]   rsp_cursor_col,
   input logic [twc_pkg::ROW_W-1:0]   rsp_cursor_row
);
   import twc_pkg::*;

   // cursor always lands on the screen
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_cursor_col) < 32'(COLUMNS))
      else $error("cursor column off screen");

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_cursor_row) < 32'(ROWS))
      else $error("cursor row off screen");

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_cell_value)
         && $stable(rsp_cursor_col) && $stable(rsp_cursor_row))
      else $error("stalled response changed");

   // the blanking sweep after reset holds off requests
   a_init_stall: assert property (@(posedge clock)
      $past(reset) |-> req_stall)
      else $error("request accepted during reset sweep");

endmodule

bind text_console_writer twc_checker u_twc_checker (.*);
